### rtl/lzcm_pkg.sv
package lzcm_pkg;

   localparam int LONG_OFFSET_BITS  = 11;
   localparam int SHORT_OFFSET_BITS = 6;
   localparam int LANES             = 8;

   // history and counters
   localparam int HIST_AW    = LONG_OFFSET_BITS;
   localparam int HIST_DEPTH = 1 << HIST_AW;
   localparam int OFF_W      = HIST_AW + 1;
   localparam int PROD_W     = HIST_AW + 1;

   // match length fields
   localparam int LONG_LEN_W     = 16 - LONG_OFFSET_BITS;
   localparam int SHORT_BASE_LEN = 2;
   localparam int LONG_BASE_LEN  = 3;
   localparam int LEN_MAX        = (1 << LONG_LEN_W) - 1 + LONG_BASE_LEN + 255;
   localparam int LEN_W          = $clog2(LEN_MAX + 1);

   // output packing
   localparam int OUT_W     = 64;
   localparam int MAX_LANES = OUT_W / 8;
   localparam int LANE_W    = $clog2(MAX_LANES);
   localparam int COUNT_W   = 4;

   // control byte flag index
   localparam int FLAG_IDX_W = 4;
   localparam int CTRL_EMPTY = 8;

   typedef struct packed {
      logic              start;
      logic              clear;
      logic              run;
      logic              is_lit;
      logic [7:0]        data;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  len;
   } cmd_type;

endpackage

### rtl/lzcm_if.sv
interface lzcm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_block;

   modport source (output valid, output data_byte, output first_of_block, input ready);
   modport sink (input valid, input data_byte, input first_of_block, output ready);
endinterface

interface lzcm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lzcm_pkg::OUT_W-1:0]      out_bytes;
   logic [lzcm_pkg::COUNT_W-1:0]    byte_count;
   logic                            last_of_run;
   logic                            offset_error;

   modport source (output valid, output out_bytes, output byte_count, output last_of_run,
                   output offset_error, input ready);
   modport sink (input valid, input out_bytes, input byte_count, input last_of_run,
                 input offset_error, output ready);
endinterface

### rtl/lz_copymap_decompressor.sv
// Timing: a request is taken only while idle; copied bytes leave the history RAM at one per
//   cycle when not stalled; a result is registered the cycle after its eighth or final byte.
// Flow: a request yields no byte or N bytes (N = 1 to 289); no new request is taken until
//   all N are written, paced by the single read port of the history RAM.
//   A held result stalls the copy only when the next result is complete.
// Reset: synchronous, active high; clears parser, pointers and result state, not the RAM.
module lz_copymap_decompressor (
   input  logic       clock,
   input  logic       reset,
   lzcm_req_if.sink   req_ch,
   lzcm_rsp_if.source rsp_ch
);

   lzcm_pkg::cmd_type                cmd;
   logic                             idle;
   logic                             accept;
   logic                             wr_en;
   logic [lzcm_pkg::HIST_AW-1:0]     wr_addr;
   logic [7:0]                       wr_data;
   logic                             rd_en;
   logic [lzcm_pkg::HIST_AW-1:0]     rd_addr;
   logic [7:0]                       rd_data;

   assign req_ch.ready = idle;
   assign accept       = req_ch.valid && idle;

   lzcm_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_ch.data_byte),
      .first_of_block (req_ch.first_of_block),
      .cmd            (cmd)
   );

   lzcm_hist_ram u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzcm_copy_engine u_copy_engine (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .idle    (idle),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rsp     (rsp_ch)
   );

endmodule

### rtl/lzcm_hist_ram.sv
module lzcm_hist_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [lzcm_pkg::HIST_AW-1:0] wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic                         rd_en,
   input  logic [lzcm_pkg::HIST_AW-1:0] rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] mem [lzcm_pkg::HIST_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lzcm_parser.sv
module lzcm_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              first_of_block,
   output lzcm_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {PH_TOKEN, PH_SECOND, PH_LONG_HI, PH_EXT} phase_type;

   localparam int LOB = lzcm_pkg::LONG_OFFSET_BITS;
   localparam int SOB = lzcm_pkg::SHORT_OFFSET_BITS;
   localparam int FW  = lzcm_pkg::FLAG_IDX_W;
   localparam int OW  = lzcm_pkg::OFF_W;
   localparam int LW  = lzcm_pkg::LEN_W;

   phase_type     phase_ff, phase_in, ph;
   logic [7:0]    ctrl_ff, ctrl_in, ctrl;
   logic [FW-1:0] bi_ff, bi_in, bi, bi2;
   logic [7:0]    held_low_ff, held_low_in, hlow;
   logic [7:0]    held_high_ff, held_high_in, hhigh;
   logic          take2;
   logic [15:0]   long_word;
   logic [7:0]    long_ext;
   logic [OW-1:0] long_off;
   logic [LW-1:0] long_len;

   always_comb begin
      // a block start clears the parser before this byte
      ctrl  = first_of_block ? 8'd0 : ctrl_ff;
      bi    = first_of_block ? FW'(lzcm_pkg::CTRL_EMPTY) : bi_ff;
      ph    = first_of_block ? PH_TOKEN : phase_ff;
      hlow  = first_of_block ? 8'd0 : held_low_ff;
      hhigh = first_of_block ? 8'd0 : held_high_ff;

      long_word = (ph == PH_EXT) ? {hhigh, hlow} : {data_byte, hlow};
      long_ext  = (ph == PH_EXT) ? data_byte : 8'd0;
      long_off  = OW'(long_word[LOB-1:0]) + OW'(1);
      long_len  = LW'(long_word[15:LOB]) + LW'(lzcm_pkg::LONG_BASE_LEN) + LW'(long_ext);

      ctrl_in      = ctrl;
      bi_in        = bi;
      phase_in     = ph;
      held_low_in  = hlow;
      held_high_in = hhigh;
      take2        = 1'b0;
      bi2          = bi;

      cmd.start  = accept;
      cmd.clear  = first_of_block;
      cmd.run    = 1'b0;
      cmd.is_lit = 1'b0;
      cmd.data   = data_byte;
      cmd.offset = '0;
      cmd.len    = '0;

      case (ph)
         PH_TOKEN: begin
            if (bi[FW-1]) begin
               ctrl_in = data_byte;
               bi_in   = '0;
            end else if (!ctrl[bi[2:0]]) begin
               bi_in      = bi + FW'(1);
               cmd.run    = 1'b1;
               cmd.is_lit = 1'b1;
               cmd.len    = LW'(1);
            end else begin
               bi2 = bi + FW'(1);
               if (bi2[FW-1]) begin
                  // second flag lives in the next control byte: this byte is it
                  ctrl_in  = data_byte;
                  bi_in    = '0;
                  phase_in = PH_SECOND;
               end else begin
                  take2 = 1'b1;
               end
            end
         end
         PH_SECOND: begin
            if (bi[FW-1]) begin
               ctrl_in = data_byte;
               bi_in   = '0;
            end else begin
               take2 = 1'b1;
            end
         end
         PH_LONG_HI: begin
            held_high_in = data_byte;
            if (&data_byte[7:LOB-8]) begin
               phase_in = PH_EXT;
            end else begin
               phase_in   = PH_TOKEN;
               cmd.run    = 1'b1;
               cmd.offset = long_off;
               cmd.len    = long_len;
            end
         end
         PH_EXT: begin
            phase_in   = PH_TOKEN;
            cmd.run    = 1'b1;
            cmd.offset = long_off;
            cmd.len    = long_len;
         end
         default: begin
            phase_in = PH_TOKEN;
         end
      endcase

      if (take2) begin
         bi_in = bi2 + FW'(1);
         if (ctrl[bi2[2:0]]) begin
            phase_in   = PH_TOKEN;
            cmd.run    = 1'b1;
            cmd.offset = OW'(data_byte[SOB-1:0]) + OW'(1);
            cmd.len    = LW'(data_byte[7:SOB]) + LW'(lzcm_pkg::SHORT_BASE_LEN);
         end else begin
            held_low_in = data_byte;
            phase_in    = PH_LONG_HI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TOKEN;
         ctrl_ff      <= '0;
         bi_ff        <= FW'(lzcm_pkg::CTRL_EMPTY);
         held_low_ff  <= '0;
         held_high_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         ctrl_ff      <= ctrl_in;
         bi_ff        <= bi_in;
         held_low_ff  <= held_low_in;
         held_high_ff <= held_high_in;
      end
   end

   a_ext_needs_max_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXT) |-> (&held_high_ff[7:LOB-8]))
      else $error("extension phase without maximum length field");

   a_flag_index_range: assert property (@(posedge clock) disable iff (reset)
      bi_ff <= FW'(lzcm_pkg::CTRL_EMPTY))
      else $error("flag index past control byte");

endmodule

### rtl/lzcm_copy_engine.sv
module lzcm_copy_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  lzcm_pkg::cmd_type             cmd,
   output logic                          idle,
   output logic                          wr_en,
   output logic [lzcm_pkg::HIST_AW-1:0]  wr_addr,
   output logic [7:0]                    wr_data,
   output logic                          rd_en,
   output logic [lzcm_pkg::HIST_AW-1:0]  rd_addr,
   input  logic [7:0]                    rd_data,
   lzcm_rsp_if.source                    rsp
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   localparam int AW  = lzcm_pkg::HIST_AW;
   localparam int OW  = lzcm_pkg::OFF_W;
   localparam int PW  = lzcm_pkg::PROD_W;
   localparam int LW  = lzcm_pkg::LEN_W;
   localparam int NW  = lzcm_pkg::LANE_W;
   localparam int CW  = lzcm_pkg::COUNT_W;
   localparam int DW  = lzcm_pkg::OUT_W;

   state_type     state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [PW-1:0] prod_ff, prod_in, prod_base;
   logic [LW-1:0] len_ff, len_in;
   logic [OW-1:0] off_ff, off_in;
   logic [7:0]    lit_ff, lit_in;
   logic          is_lit_ff, is_lit_in;
   logic          fwd_ff, fwd_in;
   logic [7:0]    fwd_data_ff, fwd_data_in;
   logic [DW-1:0] pack_ff, pack_in;
   logic [NW-1:0] lane_ff, lane_in;
   logic          pack_err_ff, pack_err_in;
   logic          out_valid_ff, out_valid_in;
   logic [DW-1:0] out_bytes_ff, out_bytes_in;
   logic [CW-1:0] out_count_ff, out_count_in;
   logic          out_last_ff, out_last_in;
   logic          out_err_ff, out_err_in;

   logic [7:0]    src;
   logic          err;
   logic [7:0]    val;
   logic          last_byte;
   logic          completes;
   logic          out_free;
   logic          advance;
   logic [DW-1:0] word;

   always_comb begin
      src       = is_lit_ff ? lit_ff : (fwd_ff ? fwd_data_ff : rd_data);
      err       = !is_lit_ff && (off_ff > prod_ff);
      val       = err ? 8'd0 : src;
      last_byte = (len_ff == LW'(1));
      completes = last_byte || (lane_ff == NW'(lzcm_pkg::LANES - 1));
      out_free  = !out_valid_ff || rsp.ready;
      advance   = (state_ff == ST_RUN) && (!completes || out_free);

      word = pack_ff;
      word[{lane_ff, 3'b000} +: 8] = val;

      state_in     = state_ff;
      wp_in        = wp_ff;
      prod_in      = prod_ff;
      len_in       = len_ff;
      off_in       = off_ff;
      lit_in       = lit_ff;
      is_lit_in    = is_lit_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      pack_in      = pack_ff;
      lane_in      = lane_ff;
      pack_err_in  = pack_err_ff;
      out_valid_in = out_valid_ff;
      out_bytes_in = out_bytes_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      wr_en   = advance;
      wr_addr = wp_ff;
      wr_data = val;
      rd_en   = 1'b0;
      rd_addr = AW'(wp_ff - off_ff[AW-1:0]);

      prod_base = (prod_ff == PW'(lzcm_pkg::HIST_DEPTH)) ? prod_ff : prod_ff + PW'(1);

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               if (cmd.clear) begin
                  prod_in = '0;
               end
               if (cmd.run) begin
                  state_in  = ST_RUN;
                  off_in    = cmd.offset;
                  len_in    = cmd.len;
                  lit_in    = cmd.data;
                  is_lit_in = cmd.is_lit;
                  fwd_in    = 1'b0;
                  rd_en     = !cmd.is_lit;
                  rd_addr   = AW'(wp_ff - cmd.offset[AW-1:0]);
               end
            end
         end
         ST_RUN: begin
            if (advance) begin
               wp_in   = wp_ff + AW'(1);
               prod_in = prod_base;
               len_in  = len_ff - LW'(1);
               if (completes) begin
                  out_valid_in = 1'b1;
                  out_bytes_in = word;
                  out_count_in = CW'(lane_ff) + CW'(1);
                  out_last_in  = last_byte;
                  out_err_in   = pack_err_ff || err;
                  pack_in      = '0;
                  lane_in      = '0;
                  pack_err_in  = 1'b0;
               end else begin
                  pack_in     = word;
                  lane_in     = lane_ff + NW'(1);
                  pack_err_in = pack_err_ff || err;
               end
               if (last_byte) begin
                  state_in = ST_IDLE;
               end else begin
                  // next source may be the byte written at this very edge
                  rd_en       = !is_lit_ff;
                  rd_addr     = AW'(wp_ff + AW'(1) - off_ff[AW-1:0]);
                  fwd_in      = (off_ff == OW'(1));
                  fwd_data_in = val;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         prod_ff      <= '0;
         len_ff       <= '0;
         fwd_ff       <= 1'b0;
         is_lit_ff    <= 1'b0;
         pack_ff      <= '0;
         lane_ff      <= '0;
         pack_err_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         prod_ff      <= prod_in;
         len_ff       <= len_in;
         fwd_ff       <= fwd_in;
         is_lit_ff    <= is_lit_in;
         pack_ff      <= pack_in;
         lane_ff      <= lane_in;
         pack_err_ff  <= pack_err_in;
         out_valid_ff <= out_valid_in;
      end
      off_ff       <= off_in;
      lit_ff       <= lit_in;
      fwd_data_ff  <= fwd_data_in;
      out_bytes_ff <= out_bytes_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   assign idle             = (state_ff == ST_IDLE);
   assign rsp.valid        = out_valid_ff;
   assign rsp.out_bytes    = out_bytes_ff;
   assign rsp.byte_count   = out_count_ff;
   assign rsp.last_of_run  = out_last_ff;
   assign rsp.offset_error = out_err_ff;

   a_idle_pack_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (lane_ff == '0 && !pack_err_ff))
      else $error("partial result left behind after a run");

   a_run_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (len_ff != '0))
      else $error("copy run with zero remaining length");

   a_forward_only_adjacent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && fwd_ff) |-> (off_ff == OW'(1)))
      else $error("forwarded history byte for a distant offset");

   a_prod_saturates: assert property (@(posedge clock) disable iff (reset)
      prod_ff <= PW'(lzcm_pkg::HIST_DEPTH))
      else $error("produced count beyond history size");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (advance && last_byte) |=> (state_ff == ST_IDLE && out_valid_ff && out_last_ff))
      else $error("final byte did not close the run");

endmodule

### tb/tb.sv
module tb;
   import lzcm_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LEN_FIELD_MAX = (1 << LONG_LEN_W) - 1;

   typedef enum logic [2:0] {PH_TOKEN, PH_SECOND, PH_LONG_HI, PH_EXT} parse_phase_e;

   typedef struct packed {
      logic [OUT_W-1:0]   data;
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               err;
   } lz_out_t;

   typedef struct packed {
      logic [7:0] b;
      logic       blk_start;
      logic       drain;
   } req_item_t;

   typedef struct packed {
      logic       is_flag;
      logic [7:0] val;
   } code_evt_t;

   logic clock;
   logic reset;

   lzcm_req_if req_ch();
   lzcm_rsp_if rsp_ch();

   lz_copymap_decompressor i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   // decoder shadow state
   logic [7:0]         hist_mem [HIST_DEPTH];
   logic [HIST_AW-1:0] wr_ptr;
   int                 blk_count;
   logic [7:0]         ctrl_byte;
   int                 flag_idx;
   parse_phase_e       phase;
   logic [7:0]         low_hold;
   logic [7:0]         high_hold;

   lz_out_t acc;
   int      lane;
   lz_out_t step_out [$];
   lz_out_t expected_out [$];

   // stream builder
   code_evt_t enc_evt [$];
   bit        enc_flags [$];
   int        gen_made;
   req_item_t send_q [$];

   req_item_t cur_req;
   bit        in_flight;
   int        hold_cycles;
   int        stall_cycles;
   bit        send_calm;
   bit        recv_calm;
   int        idle_cycles;

   int fail_count;
   int results_seen;
   int err_results;
   int bytes_sent;
   int blocks_built;

   function automatic void parser_clear();
      ctrl_byte = 8'h00;
      flag_idx  = CTRL_EMPTY;
      phase     = PH_TOKEN;
      low_hold  = 8'h00;
      high_hold = 8'h00;
      blk_count = 0;
   endfunction

   function automatic bit take_flag();
      bit f = ctrl_byte[flag_idx[2:0]];
      flag_idx++;
      return f;
   endfunction

   function automatic void put_byte(input logic [7:0] v, input logic bad);
      hist_mem[wr_ptr] = v;
      wr_ptr = wr_ptr + 1'b1;
      if (blk_count < HIST_DEPTH) blk_count++;
      acc.data  = acc.data | (OUT_W'(v) << (8 * lane));
      acc.count = COUNT_W'(lane + 1);
      acc.err   = acc.err | bad;
      lane++;
      if (lane == LANES) begin
         step_out.push_back(acc);
         acc  = '0;
         lane = 0;
      end
   endfunction

   function automatic void copy_run(input int off, input int len);
      logic [HIST_AW-1:0] rd;
      for (int i = 0; i < len; i++) begin
         rd = wr_ptr - off[HIST_AW-1:0];
         // reaching before the block start yields a zero byte
         if (off > blk_count) put_byte(8'h00, 1'b1);
         else put_byte(hist_mem[rd], 1'b0);
      end
   endfunction

   function automatic void long_copy(input int ext);
      logic [15:0] word = {high_hold, low_hold};
      copy_run(int'(word[HIST_AW-1:0]) + 1,
               int'(word >> LONG_OFFSET_BITS) + LONG_BASE_LEN + ext);
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic blk_start);
      lz_out_t res;
      if (blk_start) parser_clear();
      acc  = '0;
      lane = 0;
      step_out.delete();
      if (phase == PH_TOKEN) begin
         if (flag_idx >= CTRL_EMPTY) begin
            ctrl_byte = b;
            flag_idx  = 0;
            return;
         end
         if (!take_flag()) put_byte(b, 1'b0);
         else phase = PH_SECOND;
      end
      if (phase == PH_SECOND) begin
         // control bytes may also sit between the two flags of a match
         if (flag_idx >= CTRL_EMPTY) begin
            ctrl_byte = b;
            flag_idx  = 0;
            return;
         end
         if (take_flag()) begin
            phase = PH_TOKEN;
            copy_run(int'(b[SHORT_OFFSET_BITS-1:0]) + 1,
                     int'(b >> SHORT_OFFSET_BITS) + SHORT_BASE_LEN);
         end else begin
            low_hold = b;
            phase    = PH_LONG_HI;
            return;
         end
      end else if (phase == PH_LONG_HI) begin
         high_hold = b;
         if (((int'(b) << 8) >> LONG_OFFSET_BITS) + LONG_BASE_LEN == (1 << LONG_LEN_W) + 2) begin
            phase = PH_EXT;
            return;
         end
         phase = PH_TOKEN;
         long_copy(0);
      end else if (phase == PH_EXT) begin
         phase = PH_TOKEN;
         long_copy(int'(b));
      end
      if (lane != 0) step_out.push_back(acc);
      if (step_out.size() > 0) begin
         res = step_out.pop_back();
         res.last = 1'b1;
         step_out.push_back(res);
      end
      foreach (step_out[i]) expected_out.push_back(step_out[i]);
   endfunction

   function automatic void enc_flag(input bit f);
      code_evt_t e;
      e.is_flag = 1'b1;
      e.val     = 8'h00;
      enc_evt.push_back(e);
      enc_flags.push_back(f);
   endfunction

   function automatic void enc_byte(input logic [7:0] v);
      code_evt_t e;
      e.is_flag = 1'b0;
      e.val     = v;
      enc_evt.push_back(e);
   endfunction

   function automatic void enc_lit(input logic [7:0] v);
      enc_flag(1'b0);
      enc_byte(v);
      gen_made++;
   endfunction

   function automatic void enc_short(input int len, input int off);
      enc_flag(1'b1);
      enc_flag(1'b1);
      enc_byte(8'(((len - SHORT_BASE_LEN) << SHORT_OFFSET_BITS) | (off - 1)));
      gen_made += len;
   endfunction

   function automatic void enc_long(input int len, input int off);
      int lf = (len - LONG_BASE_LEN > LEN_FIELD_MAX) ? LEN_FIELD_MAX : len - LONG_BASE_LEN;
      logic [15:0] word = 16'((lf << LONG_OFFSET_BITS) | (off - 1));
      enc_flag(1'b1);
      enc_flag(1'b0);
      enc_byte(word[7:0]);
      enc_byte(word[15:8]);
      if (lf == LEN_FIELD_MAX) enc_byte(8'(len - LONG_BASE_LEN - lf));
      gen_made += len;
   endfunction

   // mostly offsets within the bytes made so far; now and then anywhere
   function automatic int pick_off(input int maxo);
      int lim = (gen_made < maxo) ? gen_made : maxo;
      if (lim == 0 || $urandom_range(0, 11) == 0) return $urandom_range(1, maxo);
      return $urandom_range(1, lim);
   endfunction

   // interleave control bytes where the decoder runs out of flags
   function automatic void enc_close(input bit cut_tail, input bit pause);
      req_item_t blk [$];
      req_item_t it;
      int fi;
      int used;
      fi = 0;
      used = 8;
      it.blk_start = 1'b0;
      it.drain = 1'b0;
      foreach (enc_evt[i]) begin
         if (enc_evt[i].is_flag) begin
            if (used == 8) begin
               for (int k = 0; k < 8; k++)
                  it.b[k] = (fi + k < enc_flags.size()) ? enc_flags[fi + k] : 1'($urandom);
               blk.push_back(it);
               used = 0;
            end
            used++;
            fi++;
         end else begin
            it.b = enc_evt[i].val;
            blk.push_back(it);
         end
      end
      if (cut_tail && blk.size() > 3)
         repeat ($urandom_range(1, 2)) blk.delete(blk.size() - 1);
      if (blk.size() > 0) begin
         it = blk[0];
         it.blk_start = 1'b1;
         it.drain = pause;
         blk[0] = it;
      end
      foreach (blk[i]) send_q.push_back(blk[i]);
      enc_evt.delete();
      enc_flags.delete();
      gen_made = 0;
      blocks_built++;
   endfunction

   function automatic int idle_draw(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      if (fail_count <= 50)
         $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
   endtask

   always @(posedge clock) begin : req_driver
      logic go;
      if (reset) begin
         req_ch.valid <= 1'b0;
         in_flight = 1'b0;
         hold_cycles = 0;
      end else begin
         go = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            decode_byte(cur_req.b, cur_req.blk_start);
            bytes_sent++;
            go = 1'b0;
            in_flight = 1'b0;
            hold_cycles = idle_draw(send_calm);
         end
         if (!go) begin
            if (hold_cycles > 0) hold_cycles--;
            else if (send_q.size() > 0 && !(send_q[0].drain && expected_out.size() != 0)) begin
               cur_req = send_q.pop_front();
               go = 1'b1;
               in_flight = 1'b1;
               req_ch.data_byte      <= cur_req.b;
               req_ch.first_of_block <= cur_req.blk_start;
            end
         end
         req_ch.valid <= go;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      lz_out_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_out.size() == 0) begin
               report_mismatch("unexpected result", rsp_ch.out_bytes, '0);
            end else begin
               want = expected_out.pop_front();
               if (want.err) err_results++;
               if (rsp_ch.out_bytes !== want.data)
                  report_mismatch("out_bytes", rsp_ch.out_bytes, want.data);
               if (rsp_ch.byte_count !== want.count)
                  report_mismatch("byte_count", rsp_ch.byte_count, want.count);
               if (rsp_ch.last_of_run !== want.last)
                  report_mismatch("last_of_run", rsp_ch.last_of_run, want.last);
               if (rsp_ch.offset_error !== want.err)
                  report_mismatch("offset_error", rsp_ch.offset_error, want.err);
            end
            stall_cycles = idle_draw(recv_calm);
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int target;
      int kind;
      int n;
      int r;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.first_of_block = 1'b0;
      rsp_ch.ready = 1'b0;
      wr_ptr = '0;
      parser_clear();

      // every token kind and field extreme; the ninth flag lands inside a long match
      enc_lit(8'h00);
      enc_lit(8'hFF);
      enc_lit(8'h5A);
      enc_short(2, 1);
      enc_short(5, 64);
      enc_long(3, 1);
      enc_long(289, 2048);
      enc_long(34, 3);
      enc_lit(8'hA5);
      enc_close(1'b0, 1'b0);
      // abandon a block inside a long match header
      enc_lit(8'($urandom));
      enc_long(4, 1);
      enc_close(1'b1, 1'b0);
      // hold the sender until the pipe is empty, then a match starting before the block
      enc_lit(8'h3C);
      enc_short(3, 2);
      enc_close(1'b0, 1'b1);

      target = 120;
      for (int blk = 0; send_q.size() < target; blk++) begin
         kind = $urandom_range(0, 9);
         if (blk == 1) begin
            // run past the history size so the block counter saturates
            repeat (3) enc_lit(8'($urandom));
            repeat (8) enc_long(289, $urandom_range(1, 3));
            enc_long(10, 2048);
            enc_short(5, 64);
            enc_lit(8'($urandom));
            enc_close(1'b0, 1'b1);
         end else if (kind == 0) begin
            n = $urandom_range(4, 20);
            repeat (n) enc_byte(8'($urandom));
            enc_close(1'b0, $urandom_range(0, 5) == 0);
         end else begin
            n = $urandom_range(3, 20);
            repeat (n) begin
               r = $urandom_range(0, 7);
               if (r < 4) enc_lit(8'($urandom));
               else if (r < 6) enc_short($urandom_range(2, 5), pick_off(64));
               else if ($urandom_range(0, 7) == 0)
                  enc_long($urandom_range(34, 289), pick_off(HIST_DEPTH));
               else
                  enc_long($urandom_range(3, 33), pick_off(HIST_DEPTH));
            end
            enc_close($urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (send_q.size() != 0 || in_flight || expected_out.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Decoded %0d compressed bytes in %0d blocks into %0d results", bytes_sent,
               blocks_built, results_seen);
      $display("%0d results carried an offset error; %0d field mismatches", err_results,
               fail_count);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
